// ----- hdl/ycc_pkg.sv -----
// types and constants for the ycbcr to rgb converter
// holds payload structs, register indexes, reset values and fixed-point widths
// no dependencies
package ycc_pkg;

   // output sample width and full-scale code
   localparam int OUT_BITS = 8;
   localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

   // configuration port
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_OFFSET   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_SCALE    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMA_OFFSET = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMA_SCALE  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_FROM_V    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_FROM_U  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_FROM_V  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_FROM_U   = 4'd7;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] RST_LUMA_OFFSET   = 16'd4096;
   localparam logic [CSR_DATA_W-1:0] RST_LUMA_SCALE    = 16'd9539;
   localparam logic [CSR_DATA_W-1:0] RST_CHROMA_OFFSET = 16'd32768;
   localparam logic [CSR_DATA_W-1:0] RST_CHROMA_SCALE  = 16'd9325;
   localparam logic [CSR_DATA_W-1:0] RST_RED_FROM_V    = 16'd12901;
   localparam logic [CSR_DATA_W-1:0] RST_GREEN_FROM_U  = 16'd1534;
   localparam logic [CSR_DATA_W-1:0] RST_GREEN_FROM_V  = 16'd3835;
   localparam logic [CSR_DATA_W-1:0] RST_BLUE_FROM_U   = 16'd15201;

   // datapath widths
   localparam int DIFF_W = 17;                   // code*256 - offset, signed
   localparam int SMP_W  = 33;                   // scaled sample, Q.21 signed
   localparam int Y34_W  = SMP_W + 13;           // luma moved to Q.34
   localparam int PROD_W = 49;                   // coefficient times sample, Q.34
   localparam int SUM_W  = 51;                   // channel sum, Q.34 signed
   localparam int CLP_W  = 42;                   // clamped channel, below 255<<34
   localparam int FRAC_SHIFT = 34;
   localparam int T_W    = CLP_W + OUT_BITS + 1; // c*OUT_MAX + half step
   localparam int Q_W    = OUT_BITS + 8;         // quotient by 2^34, below 2^Q_W

   localparam logic [CLP_W-1:0] FULL_SCALE = CLP_W'(64'd255 << 34);
   localparam logic [CLP_W-1:0] HALF_STEP  = CLP_W'(64'd255 << 33);

   // exact divide by 255 through a reciprocal, valid for values below 2^Q_W
   localparam int RCP_SHIFT = OUT_BITS + 16;
   localparam int R_W = OUT_BITS + 10;
   localparam logic [R_W-1:0] RECIP = R_W'(((64'd1 << RCP_SHIFT) + 64'd254) / 64'd255);
   localparam int MUL5_W = Q_W + R_W;

   // payload of one input transaction
   typedef struct packed {
      logic [7:0] luma_code;
      logic [7:0] blue_diff_code;
      logic [7:0] red_diff_code;
   } ycc_type;

   // payload of one result transaction
   typedef struct packed {
      logic [OUT_BITS-1:0] red;
      logic [OUT_BITS-1:0] green;
      logic [OUT_BITS-1:0] blue;
   } rgb_type;

endpackage

// ----- hdl/ycbcr_to_rgb_converter.sv -----
// ycbcr to rgb converter: five-stage pipelined pixel color space conversion, uses ycc_pkg
// throughput: one pixel per clock, busy is never raised; the five register stages hold the
//   scale multipliers, coefficient multipliers, sums and clamp, rounding, divide by 255
// reset: synchronous, clears all pipeline valid bits and loads the register defaults
// the receiver cannot stall, so every result is presented for exactly one cycle
module ycbcr_to_rgb_converter
   import ycc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ycc_type               req_data,
   output logic                  rsp_valid,
   output rgb_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NUM_STAGES = 5;

   // configuration registers
   logic [CSR_DATA_W-1:0] luma_offset_ff, luma_scale_ff, chroma_offset_ff, chroma_scale_ff;
   logic [CSR_DATA_W-1:0] red_from_v_ff, green_from_u_ff, green_from_v_ff, blue_from_u_ff;

   // pipeline valid bits
   logic [NUM_STAGES-1:0] vld_ff, vld_in;

   // stage 1: scaled samples (y, u, v)
   logic signed [SMP_W-1:0] smp_ff [3];
   logic signed [SMP_W-1:0] smp_in [3];

   // stage 2: luma in Q.34 and the four coefficient products
   logic signed [Y34_W-1:0]  y34_ff, y34_in;
   logic signed [PROD_W-1:0] prd_ff [4];
   logic signed [PROD_W-1:0] prd_in [4];

   // stage 3: clamped channels and saturation flags
   logic signed [SUM_W-1:0] sum [3];
   logic [CLP_W-1:0]        clp_ff [3];
   logic [CLP_W-1:0]        clp_in [3];
   logic [2:0]              sat3_ff, sat3_in;

   // stage 4: channel times OUT_MAX plus rounding offset, divided by 2^34
   logic [Q_W-1:0] quo_ff [3];
   logic [Q_W-1:0] quo_in [3];
   logic [2:0]     sat4_ff, sat4_in;

   // stage 5: output samples
   logic [OUT_BITS-1:0] out_ff [3];
   logic [OUT_BITS-1:0] out_in [3];

   // pipeline never stalls
   assign busy = 1'b0;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         luma_offset_ff   <= RST_LUMA_OFFSET;
         luma_scale_ff    <= RST_LUMA_SCALE;
         chroma_offset_ff <= RST_CHROMA_OFFSET;
         chroma_scale_ff  <= RST_CHROMA_SCALE;
         red_from_v_ff    <= RST_RED_FROM_V;
         green_from_u_ff  <= RST_GREEN_FROM_U;
         green_from_v_ff  <= RST_GREEN_FROM_V;
         blue_from_u_ff   <= RST_BLUE_FROM_U;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LUMA_OFFSET:   luma_offset_ff   <= csr_wdata;
            CSR_LUMA_SCALE:    luma_scale_ff    <= csr_wdata;
            CSR_CHROMA_OFFSET: chroma_offset_ff <= csr_wdata;
            CSR_CHROMA_SCALE:  chroma_scale_ff  <= csr_wdata;
            CSR_RED_FROM_V:    red_from_v_ff    <= csr_wdata;
            CSR_GREEN_FROM_U:  green_from_u_ff  <= csr_wdata;
            CSR_GREEN_FROM_V:  green_from_v_ff  <= csr_wdata;
            CSR_BLUE_FROM_U:   blue_from_u_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // valid bits travel with the data
   assign vld_in = {vld_ff[NUM_STAGES-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: subtract offsets and apply luma / chroma gain
   always_comb begin
      logic [7:0]               code   [3];
      logic [CSR_DATA_W-1:0]    offs   [3];
      logic [CSR_DATA_W-1:0]    gain   [3];
      logic signed [DIFF_W-1:0] diff;
      logic signed [2*DIFF_W-1:0] prod;
      code[0] = req_data.luma_code;
      code[1] = req_data.blue_diff_code;
      code[2] = req_data.red_diff_code;
      offs[0] = luma_offset_ff;
      offs[1] = chroma_offset_ff;
      offs[2] = chroma_offset_ff;
      gain[0] = luma_scale_ff;
      gain[1] = chroma_scale_ff;
      gain[2] = chroma_scale_ff;
      for (int i = 0; i < 3; i++) begin
         diff = $signed({1'b0, code[i], 8'h00}) - $signed({1'b0, offs[i]});
         prod = diff * $signed({1'b0, gain[i]});
         smp_in[i] = prod[SMP_W-1:0];
      end
   end

   // stage 2: coefficient products, luma moved to Q.34
   always_comb begin
      logic [CSR_DATA_W-1:0]     coef [4];
      logic signed [SMP_W-1:0]   src  [4];
      logic signed [SMP_W+DIFF_W-1:0] prod;
      coef[0] = red_from_v_ff;
      coef[1] = green_from_u_ff;
      coef[2] = green_from_v_ff;
      coef[3] = blue_from_u_ff;
      src[0]  = smp_ff[2];
      src[1]  = smp_ff[1];
      src[2]  = smp_ff[2];
      src[3]  = smp_ff[1];
      for (int i = 0; i < 4; i++) begin
         prod = src[i] * $signed({1'b0, coef[i]});
         prd_in[i] = prod[PROD_W-1:0];
      end
      y34_in = {smp_ff[0], 13'd0};
   end

   // stage 3: channel sums and clamp to 0..255 code units
   always_comb begin
      sum[0] = SUM_W'(y34_ff) + SUM_W'(prd_ff[0]);
      sum[1] = SUM_W'(y34_ff) - SUM_W'(prd_ff[1]) - SUM_W'(prd_ff[2]);
      sum[2] = SUM_W'(y34_ff) + SUM_W'(prd_ff[3]);
      for (int i = 0; i < 3; i++) begin
         if (sum[i] <= 0) begin
            clp_in[i]  = '0;
            sat3_in[i] = 1'b0;
         end else if (sum[i] >= $signed({{(SUM_W-CLP_W){1'b0}}, FULL_SCALE})) begin
            clp_in[i]  = '0;
            sat3_in[i] = 1'b1;
         end else begin
            clp_in[i]  = sum[i][CLP_W-1:0];
            sat3_in[i] = 1'b0;
         end
      end
   end

   // stage 4: c*OUT_MAX by shift and subtract, add half step, drop 34 fraction bits
   always_comb begin
      logic [T_W-1:0] t;
      for (int i = 0; i < 3; i++) begin
         t = T_W'({clp_ff[i], {OUT_BITS{1'b0}}}) - T_W'(clp_ff[i]) + T_W'(HALF_STEP);
         quo_in[i] = t[FRAC_SHIFT +: Q_W];
      end
      sat4_in = sat3_ff;
   end

   // stage 5: divide by 255 through the reciprocal, saturate
   always_comb begin
      logic [MUL5_W-1:0] prod;
      for (int i = 0; i < 3; i++) begin
         prod = MUL5_W'(quo_ff[i]) * MUL5_W'(RECIP);
         out_in[i] = sat4_ff[i] ? OUT_MAX : prod[RCP_SHIFT +: OUT_BITS];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      smp_ff  <= smp_in;
      y34_ff  <= y34_in;
      prd_ff  <= prd_in;
      clp_ff  <= clp_in;
      sat3_ff <= sat3_in;
      quo_ff  <= quo_in;
      sat4_ff <= sat4_in;
      out_ff  <= out_in;
   end

   // result transaction
   assign rsp_valid      = vld_ff[NUM_STAGES-1];
   assign rsp_data.red   = out_ff[0];
   assign rsp_data.green = out_ff[1];
   assign rsp_data.blue  = out_ff[2];

   // every result traces back to an accepted transaction
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, NUM_STAGES))
      else $error("result without matching accepted transaction");

   // an accepted transaction always produces a result
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted transaction produced no result");

   // a non-positive red sum comes out as zero
   a_red_floor: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && sum[0] <= 0) |-> ##3 (rsp_valid && rsp_data.red == '0))
      else $error("negative red channel not clamped to zero");

   // a green sum at or above full scale comes out as the maximum code
   a_green_ceiling: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && sum[1] >= $signed({{(SUM_W-CLP_W){1'b0}}, FULL_SCALE}))
      |-> ##3 (rsp_valid && rsp_data.green == OUT_MAX))
      else $error("saturated green channel not at full scale");

endmodule
